[sv/hbq_pkg.sv]
// Host byte queue package: sizes, byte codes, register indexes, shared types.
// Ring pointer helpers used by the queue core. No dependencies.
package hbq_pkg;

  localparam int QUEUE_DEPTH = 1024;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int BYTE_W      = 8;
  localparam int FILL_W      = 10;
  localparam int TOTAL_W     = 32;
  localparam int CFG_DATA_W  = 10;
  localparam int CFG_IDX_W   = 1;

  localparam logic [FILL_W-1:0] FILL_MAX = '1;

  localparam logic [BYTE_W-1:0] CANCEL_BYTE = 8'h18;
  localparam logic [BYTE_W-1:0] QUERY_BYTE  = 8'h3F;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_QUEUE_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BP_LEVEL     = 1'd1;

  localparam logic [FILL_W-1:0] BP_LEVEL_RESET = 10'd768;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  typedef struct packed {
    logic              queue_enable;
    logic [FILL_W-1:0] backpressure_level;
  } cfg_t;

  typedef struct packed {
    logic               push_accepted;
    logic               push_dropped;
    logic               query_deferred;
    logic               out_valid;
    logic [BYTE_W-1:0]  out_byte;
    logic               out_is_query;
    logic [FILL_W-1:0]  fill_level;
    logic               backpressure;
    logic [TOTAL_W-1:0] defer_total;
    logic [TOTAL_W-1:0] drop_total;
  } res_t;

  function automatic ptr_t ring_next(input ptr_t p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic cnt_t ring_used(input ptr_t w, input ptr_t r);
    if (w >= r) return CNT_W'(w) - CNT_W'(r);
    return CNT_W'(QUEUE_DEPTH) - CNT_W'(r) + CNT_W'(w);
  endfunction

endpackage

[sv/host_byte_queue_realtime_filter_top.sv]
// Host byte queue top level: configuration registers, queue core, byte store.
// Uses hbq_pkg, hbq_core and hbq_ram.
//
// Requests enter on in_valid/in_ready with cmd, host_byte and sender_busy.
// cmd push queues host_byte (cancel byte clears the queue first, a status
// query is deferred while data is held or the sender is busy); cmd pop takes
// the oldest byte, or the deferred query once the queue is empty.
// Every request yields exactly one result on res_valid/res_ready.
// A push or a pop that needs no stored byte has its result registered in the
// cycle after acceptance; a pop of a stored byte first waits in ST_READ for
// the byte store RAM read. One request is in flight at a time: pushes are
// taken at one request per cycle while res_ready is high, and a pop that
// reads the store holds off the next request until its result is registered.
// The result register lets a new request be accepted in the cycle its
// predecessor's result is taken; while res_ready is low the result holds and
// in_ready stays low.
// Reset empties the queue, clears the deferred query and both totals, and
// sets queue_enable to 1 and backpressure_level to 768. Store contents are
// not cleared; only bytes written since the last clear are ever read.
// cfg_we writes register cfg_index (0 queue_enable, 1 backpressure_level)
// from cfg_data; the write is registered.
module host_byte_queue_realtime_filter_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [hbq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hbq_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            cmd,
  input  logic [hbq_pkg::BYTE_W-1:0]      host_byte,
  input  logic                            sender_busy,
  output logic                            res_valid,
  input  logic                            res_ready,
  output logic                            push_accepted,
  output logic                            push_dropped,
  output logic                            query_deferred,
  output logic                            out_valid,
  output logic [hbq_pkg::BYTE_W-1:0]      out_byte,
  output logic                            out_is_query,
  output logic [hbq_pkg::FILL_W-1:0]      fill_level,
  output logic                            backpressure,
  output logic [hbq_pkg::TOTAL_W-1:0]     defer_total,
  output logic [hbq_pkg::TOTAL_W-1:0]     drop_total
);
  import hbq_pkg::*;

  cfg_t              cfg;
  res_t              res;
  logic              mem_en;
  logic              mem_we;
  ptr_t              mem_addr;
  logic [BYTE_W-1:0] mem_wdata;
  logic [BYTE_W-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.queue_enable       <= 1'b1;
      cfg.backpressure_level <= BP_LEVEL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_QUEUE_ENABLE: cfg.queue_enable       <= cfg_data[0];
        REG_BP_LEVEL:     cfg.backpressure_level <= cfg_data[FILL_W-1:0];
        default: ;
      endcase
    end
  end

  hbq_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .host_byte   (host_byte),
    .sender_busy (sender_busy),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_en      (mem_en),
    .mem_we      (mem_we),
    .mem_addr    (mem_addr),
    .mem_wdata   (mem_wdata),
    .mem_rdata   (mem_rdata)
  );

  hbq_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (BYTE_W)
  ) u_store (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign push_accepted  = res.push_accepted;
  assign push_dropped   = res.push_dropped;
  assign query_deferred = res.query_deferred;
  assign out_valid      = res.out_valid;
  assign out_byte       = res.out_byte;
  assign out_is_query   = res.out_is_query;
  assign fill_level     = res.fill_level;
  assign backpressure   = res.backpressure;
  assign defer_total    = res.defer_total;
  assign drop_total     = res.drop_total;

endmodule

[sv/hbq_ram.sv]
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module hbq_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) mem[addr] <= wdata;
      else    rdata     <= mem[addr];
    end
  end

endmodule

[sv/hbq_core.sv]
// Queue core: ring pointers, cancel/query filtering, counters, result register.
// Uses hbq_pkg; drives the byte store in hbq_ram.
module hbq_core (
  input  logic                       clk,
  input  logic                       rst,
  input  hbq_pkg::cfg_t              cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       cmd,
  input  logic [hbq_pkg::BYTE_W-1:0] host_byte,
  input  logic                       sender_busy,
  output logic                       res_valid,
  input  logic                       res_ready,
  output hbq_pkg::res_t              res,
  output logic                       mem_en,
  output logic                       mem_we,
  output hbq_pkg::ptr_t              mem_addr,
  output logic [hbq_pkg::BYTE_W-1:0] mem_wdata,
  input  logic [hbq_pkg::BYTE_W-1:0] mem_rdata
);
  import hbq_pkg::*;

  state_t               state, state_next;
  ptr_t                 wr_ptr, wr_ptr_next;
  ptr_t                 rd_ptr, rd_ptr_next;
  logic                 query_pending, query_pending_next;
  logic [TOTAL_W-1:0]   defer_count, defer_count_next;
  logic [TOTAL_W-1:0]   drop_count, drop_count_next;
  logic                 res_valid_next;
  res_t                 res_next;
  cnt_t                 used;
  logic [TOTAL_W-1:0]   used_wide;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      wr_ptr        <= '0;
      rd_ptr        <= '0;
      query_pending <= 1'b0;
      defer_count   <= '0;
      drop_count    <= '0;
      res_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      wr_ptr        <= wr_ptr_next;
      rd_ptr        <= rd_ptr_next;
      query_pending <= query_pending_next;
      defer_count   <= defer_count_next;
      drop_count    <= drop_count_next;
      res_valid     <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

  always_comb begin
    state_next         = state;
    wr_ptr_next        = wr_ptr;
    rd_ptr_next        = rd_ptr;
    query_pending_next = query_pending;
    defer_count_next   = defer_count;
    drop_count_next    = drop_count;
    res_valid_next     = res_valid && !res_ready;
    res_next           = res;
    mem_en             = 1'b0;
    mem_we             = 1'b0;
    mem_addr           = rd_ptr;
    mem_wdata          = host_byte;
    used               = '0;
    used_wide          = '0;
    in_ready           = (state == ST_IDLE) && (!res_valid || res_ready);

    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          res_next       = '0;
          res_valid_next = 1'b1;
          if (cmd == CMD_PUSH) begin
            if (!cfg.queue_enable) begin
              res_next.push_dropped = 1'b1;
              drop_count_next       = drop_count + 1'b1;
            end else begin
              if (host_byte == CANCEL_BYTE) begin
                wr_ptr_next        = '0;
                rd_ptr_next        = '0;
                query_pending_next = 1'b0;
              end
              if (host_byte == QUERY_BYTE &&
                  (ring_used(wr_ptr_next, rd_ptr_next) != '0 || sender_busy)) begin
                query_pending_next      = 1'b1;
                defer_count_next        = defer_count + 1'b1;
                res_next.query_deferred = 1'b1;
                res_next.push_accepted  = 1'b1;
              end else if (ring_next(wr_ptr_next) == rd_ptr_next) begin
                res_next.push_dropped = 1'b1;
                drop_count_next       = drop_count + 1'b1;
              end else begin
                mem_en                 = 1'b1;
                mem_we                 = 1'b1;
                mem_addr               = wr_ptr_next;
                wr_ptr_next            = ring_next(wr_ptr_next);
                res_next.push_accepted = 1'b1;
              end
            end
          end else if (cfg.queue_enable) begin
            if (rd_ptr != wr_ptr) begin
              // byte arrives from the store next cycle
              mem_en             = 1'b1;
              mem_addr           = rd_ptr;
              rd_ptr_next        = ring_next(rd_ptr);
              res_next.out_valid = 1'b1;
              res_valid_next     = 1'b0;
              state_next         = ST_READ;
            end else if (query_pending) begin
              query_pending_next    = 1'b0;
              res_next.out_valid    = 1'b1;
              res_next.out_byte     = QUERY_BYTE;
              res_next.out_is_query = 1'b1;
            end
          end
          used                  = ring_used(wr_ptr_next, rd_ptr_next);
          used_wide             = TOTAL_W'(used);
          res_next.fill_level   = (used_wide > TOTAL_W'(FILL_MAX)) ?
                                  FILL_MAX : used_wide[FILL_W-1:0];
          res_next.backpressure = used_wide >= TOTAL_W'(cfg.backpressure_level);
          res_next.defer_total  = defer_count_next;
          res_next.drop_total   = drop_count_next;
        end
      end
      ST_READ: begin
        res_next.out_byte = mem_rdata;
        res_valid_next    = 1'b1;
        state_next        = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[sv/hbq_chk.sv]
// Port-level checker for the host byte queue top level, bound to it below.
// Uses hbq_pkg.
module hbq_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic                        push_accepted,
  input logic                        push_dropped,
  input logic                        query_deferred,
  input logic                        out_valid,
  input logic [hbq_pkg::BYTE_W-1:0]  out_byte,
  input logic                        out_is_query
);
  import hbq_pkg::*;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result request dropped while stalled");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result request present after reset");

  a_push_outcome: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(push_accepted && push_dropped))
    else $error("push both accepted and dropped");

  a_pop_no_push_flags: assert property (@(posedge clk) disable iff (rst)
    res_valid && out_valid |-> !push_accepted && !push_dropped && !query_deferred)
    else $error("pop result carries push flags");

  a_query_byte: assert property (@(posedge clk) disable iff (rst)
    res_valid && out_is_query |-> out_valid && out_byte == QUERY_BYTE)
    else $error("status query result malformed");

endmodule

bind host_byte_queue_realtime_filter_top hbq_chk u_hbq_chk (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (res_valid),
  .res_ready      (res_ready),
  .push_accepted  (push_accepted),
  .push_dropped   (push_dropped),
  .query_deferred (query_deferred),
  .out_valid      (out_valid),
  .out_byte       (out_byte),
  .out_is_query   (out_is_query)
);

[tb/host_byte_queue_realtime_filter_top_tb.sv]
// Testbench for host_byte_queue_realtime_filter_top: directed table, random traffic,
// a full-queue sweep, each result checked against its table row or a cycle-free queue predictor.
// Depends on hbq_pkg and the top-level RTL only.
module host_byte_queue_realtime_filter_top_tb;
  import hbq_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    logic                   c;
    logic [BYTE_W-1:0]      hb;
    logic                   busy;
    bit                     has_want;
    res_t                   want;
  } row_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic                   cmd;
  logic [BYTE_W-1:0]      host_byte;
  logic                   sender_busy;
  logic                   res_valid;
  logic                   res_ready;
  logic                   push_accepted;
  logic                   push_dropped;
  logic                   query_deferred;
  logic                   out_valid;
  logic [BYTE_W-1:0]      out_byte;
  logic                   out_is_query;
  logic [FILL_W-1:0]      fill_level;
  logic                   backpressure;
  logic [TOTAL_W-1:0]     defer_total;
  logic [TOTAL_W-1:0]     drop_total;

  // queue mirror
  logic [BYTE_W-1:0]  sh_store [QUEUE_DEPTH];
  ptr_t               sh_wr = '0;
  ptr_t               sh_rd = '0;
  logic               sh_query = 1'b0;
  logic [TOTAL_W-1:0] sh_defers = '0;
  logic [TOTAL_W-1:0] sh_drops = '0;
  logic               sh_enable = 1'b1;
  logic [FILL_W-1:0]  sh_bp_level = BP_LEVEL_RESET;

  res_t due_results[$];
  row_t plan[$];
  int   errors = 0;
  int   snd_idle_pct = 0;
  int   rcv_stall_pct = 0;
  bit   hold_req = 1'b0;

  host_byte_queue_realtime_filter_top dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int queued_bytes();
    return (int'(sh_wr) - int'(sh_rd) + QUEUE_DEPTH) % QUEUE_DEPTH;
  endfunction

  function automatic ptr_t bump(ptr_t p);
    return ptr_t'((int'(p) + 1) % QUEUE_DEPTH);
  endfunction

  function automatic res_t next_result(logic c, logic [BYTE_W-1:0] hb, logic busy);
    res_t r;
    int   used;
    r = '0;
    if (c == CMD_PUSH) begin
      if (!sh_enable) begin
        r.push_dropped = 1'b1;
        sh_drops++;
      end else begin
        if (hb == CANCEL_BYTE) begin
          sh_wr = '0;
          sh_rd = '0;
          sh_query = 1'b0;
        end
        if (hb == QUERY_BYTE && (queued_bytes() > 0 || busy)) begin
          sh_query = 1'b1;
          sh_defers++;
          r.query_deferred = 1'b1;
          r.push_accepted = 1'b1;
        end else if (queued_bytes() == QUEUE_DEPTH - 1) begin
          r.push_dropped = 1'b1;
          sh_drops++;
        end else begin
          sh_store[sh_wr] = hb;
          sh_wr = bump(sh_wr);
          r.push_accepted = 1'b1;
        end
      end
    end else if (sh_enable) begin
      if (queued_bytes() > 0) begin
        r.out_byte = sh_store[sh_rd];
        r.out_valid = 1'b1;
        sh_rd = bump(sh_rd);
      end else if (sh_query) begin
        sh_query = 1'b0;
        r.out_byte = QUERY_BYTE;
        r.out_valid = 1'b1;
        r.out_is_query = 1'b1;
      end
    end
    used = queued_bytes();
    r.fill_level = (used > int'(FILL_MAX)) ? FILL_MAX : FILL_W'(used);
    r.backpressure = (used >= int'(sh_bp_level));
    r.defer_total = sh_defers;
    r.drop_total = sh_drops;
    return r;
  endfunction

  function automatic res_t want(bit acc, bit drp, bit dfr, bit ov, int ob, bit q,
                                int fill, bit bp, int dt, int dr);
    res_t r;
    r.push_accepted = acc;
    r.push_dropped = drp;
    r.query_deferred = dfr;
    r.out_valid = ov;
    r.out_byte = BYTE_W'(ob);
    r.out_is_query = q;
    r.fill_level = FILL_W'(fill);
    r.backpressure = bp;
    r.defer_total = TOTAL_W'(dt);
    r.drop_total = TOTAL_W'(dr);
    return r;
  endfunction

  function automatic void add_req(logic c, logic [BYTE_W-1:0] hb, logic busy,
                                  bit has_want = 1'b0, res_t w = '0);
    row_t r;
    r.kind = ROW_REQ;
    r.idx = '0;
    r.data = '0;
    r.c = c;
    r.hb = hb;
    r.busy = busy;
    r.has_want = has_want;
    r.want = w;
    plan.push_back(r);
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    row_t r;
    r = '{kind: ROW_CFG, idx: idx, data: data, c: CMD_PUSH, hb: '0, busy: 1'b0,
          has_want: 1'b0, want: '0};
    plan.push_back(r);
  endfunction

  function automatic void cmp(string name, logic [TOTAL_W-1:0] exp_v,
                              logic [TOTAL_W-1:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      errors++;
    end
  endfunction

  // called at a falling edge; returns at a falling edge with in_valid still high
  task automatic issue(logic c, logic [BYTE_W-1:0] hb, logic busy,
                       bit has_want = 1'b0, res_t w = '0);
    res_t p;
    if ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < snd_idle_pct) @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    host_byte <= hb;
    sender_busy <= busy;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p = next_result(c, hb, busy);
    due_results.push_back(has_want ? w : p);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_QUEUE_ENABLE) sh_enable = val[0];
    else sh_bp_level = val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_result();
    res_t e;
    if (due_results.size() == 0) begin
      $error("result with no request outstanding");
      errors++;
      return;
    end
    e = due_results.pop_front();
    cmp("push_accepted", e.push_accepted, push_accepted);
    cmp("push_dropped", e.push_dropped, push_dropped);
    cmp("query_deferred", e.query_deferred, query_deferred);
    cmp("out_valid", e.out_valid, out_valid);
    cmp("out_byte", e.out_byte, out_byte);
    cmp("out_is_query", e.out_is_query, out_is_query);
    cmp("fill_level", e.fill_level, fill_level);
    cmp("backpressure", e.backpressure, backpressure);
    cmp("defer_total", e.defer_total, defer_total);
    cmp("drop_total", e.drop_total, drop_total);
  endtask

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) check_result();
  end

  // result side
  initial begin
    res_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      res_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // watchdog: consecutive cycles with no request or result taken
  initial begin
    int idle_run;
    idle_run = 0;
    while (idle_run < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (res_valid && res_ready)) idle_run = 0;
      else idle_run++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic              c;
    logic [BYTE_W-1:0] hb;
    int                r;
    int                pop_pct;
    int                n;
    logic [CFG_DATA_W-1:0] lvl;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    cmd = CMD_PUSH;
    host_byte = '0;
    sender_busy = 1'b0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // directed table
    add_req(CMD_POP, 8'hC3, 1'b1, 1, want(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_req(CMD_PUSH, QUERY_BYTE, 1'b0, 1, want(1, 0, 0, 0, 0, 0, 1, 0, 0, 0));
    add_req(CMD_PUSH, QUERY_BYTE, 1'b1, 1, want(1, 0, 1, 0, 0, 0, 1, 0, 1, 0));
    add_req(CMD_PUSH, 8'h00, 1'b0);
    add_req(CMD_PUSH, 8'hFF, 1'b1);
    add_req(CMD_PUSH, CANCEL_BYTE, 1'b0, 1, want(1, 0, 0, 0, 0, 0, 1, 0, 1, 0));
    add_req(CMD_POP, 8'h00, 1'b0, 1, want(0, 0, 0, 1, CANCEL_BYTE, 0, 0, 0, 1, 0));
    add_req(CMD_POP, 8'hFF, 1'b0, 1, want(0, 0, 0, 0, 0, 0, 0, 0, 1, 0));
    add_req(CMD_PUSH, 8'hA5, 1'b0);
    add_req(CMD_PUSH, QUERY_BYTE, 1'b0);
    add_req(CMD_POP, 8'h00, 1'b1);
    add_req(CMD_POP, 8'h00, 1'b0, 1, want(0, 0, 0, 1, QUERY_BYTE, 1, 0, 0, 2, 0));
    add_req(CMD_PUSH, QUERY_BYTE, 1'b1);
    add_req(CMD_PUSH, 8'h5A, 1'b1);
    add_req(CMD_POP, 8'h00, 1'b0);
    add_req(CMD_PUSH, 8'h33, 1'b0);
    add_cfg(REG_QUEUE_ENABLE, 0);
    add_req(CMD_POP, 8'h00, 1'b0, 1, want(0, 0, 0, 0, 0, 0, 1, 0, 3, 0));
    add_req(CMD_PUSH, CANCEL_BYTE, 1'b0, 1, want(0, 1, 0, 0, 0, 0, 1, 0, 3, 1));
    add_req(CMD_PUSH, QUERY_BYTE, 1'b1);
    add_cfg(REG_QUEUE_ENABLE, 1);
    add_cfg(REG_BP_LEVEL, 0);
    add_req(CMD_POP, 8'h00, 1'b0, 1, want(0, 0, 0, 1, 8'h33, 0, 0, 1, 3, 2));
    add_req(CMD_POP, 8'h00, 1'b0, 1, want(0, 0, 0, 1, QUERY_BYTE, 1, 0, 1, 3, 2));
    add_req(CMD_POP, 8'h00, 1'b0);
    add_cfg(REG_BP_LEVEL, 1023);
    add_req(CMD_PUSH, 8'h7E, 1'b0);
    add_cfg(REG_BP_LEVEL, BP_LEVEL_RESET);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        drain_results();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        issue(plan[i].c, plan[i].hb, plan[i].busy, plan[i].has_want, plan[i].want);
      end
    end

    // random traffic in phases of idling
    for (int seg = 0; seg < 8; seg++) begin
      drain_results();
      case (seg % 4)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 74; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 74; end
        default: begin snd_idle_pct = 19; rcv_stall_pct = 19; end
      endcase
      case ($urandom_range(3))
        0: lvl = '0;
        1: lvl = '1;
        2: lvl = CFG_DATA_W'($urandom_range(8));
        default: lvl = CFG_DATA_W'($urandom_range(1023));
      endcase
      write_reg(REG_QUEUE_ENABLE, CFG_DATA_W'((seg == 5) ? 0 : 1));
      write_reg(REG_BP_LEVEL, lvl);
      if (seg == 0) hold_req = 1'b1;
      pop_pct = $urandom_range(30, 60);
      n = (seg == 5) ? 30 : 60;
      repeat (n) begin
        c = ($urandom_range(99) < pop_pct) ? CMD_POP : CMD_PUSH;
        r = $urandom_range(99);
        if (r < 4) hb = CANCEL_BYTE;
        else if (r < 16) hb = QUERY_BYTE;
        else hb = BYTE_W'($urandom_range(255));
        issue(c, hb, 1'($urandom_range(1)));
      end
    end

    // one fill to full across the pointer wrap, overflow, then cancel while full
    drain_results();
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    write_reg(REG_QUEUE_ENABLE, 1);
    write_reg(REG_BP_LEVEL, 1000);
    issue(CMD_PUSH, CANCEL_BYTE, 1'b0);
    issue(CMD_POP, 8'h00, 1'b0);
    while (queued_bytes() < QUEUE_DEPTH - 1) begin
      hb = BYTE_W'($urandom_range(255));
      if (hb == CANCEL_BYTE) hb = 8'h00;
      issue(CMD_PUSH, hb, 1'($urandom_range(1)));
    end
    repeat (3) issue(CMD_PUSH, 8'h5A, 1'($urandom_range(1)));
    issue(CMD_PUSH, CANCEL_BYTE, 1'b1);
    issue(CMD_POP, 8'h00, 1'b0);
    issue(CMD_POP, 8'h00, 1'b0);

    drain_results();
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
